// File: src/rbd_pkg.sv
// rbd_pkg: types and constants shared by the ring buffer deque.
// Request and status codes, transaction structs and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package rbd_pkg;

    // Default number of physical ring slots
    localparam int DEPTH_DEFAULT = 16;

    // Fixed field widths
    localparam int REQ_W  = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;

    // Ring size after reset
    localparam logic [CNT_W-1:0] RING_SIZE_RESET = 5'd16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
    localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Word returned by a pop or peek on an empty deque
    localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

    // Request transaction
    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] push_value;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic [STAT_W-1:0]        status;
        logic [CNT_W-1:0]         item_count;
        logic                     is_empty;
        logic                     is_full;
    } t_out;

endpackage

// File: src/ring_buffer_deque_top.sv
// ring_buffer_deque_top: double-ended queue of signed words in a ring memory.
// Depends on rbd_pkg for transaction structs, codes and defaults.
`timescale 1ns / 1ps

// One request is taken on every clock edge where start is high (busy is
// never raised), and its result appears on o_result with o_valid high for
// exactly one cycle, in the cycle after acceptance; the receiver cannot stall,
// so results must be captured when o_valid is seen. The result is held in the
// result register and the registered read port of the slot memory; head, tail and
// count update at the accepting edge, so a request may follow every clock.
// Writing the ring size (clamped to 1..DEPTH) empties the deque; do so only
// while no result is outstanding. No clearing pass runs after reset.
module ring_buffer_deque_top #(
    parameter int DEPTH = rbd_pkg::DEPTH_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  rbd_pkg::t_in              i_req,
    output logic                      o_valid,
    output rbd_pkg::t_out             o_result,
    input  logic                      i_cfg_we,
    input  logic [rbd_pkg::CNT_W-1:0] i_cfg_data
);

    localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = ((SW > rbd_pkg::CNT_W) ? SW : rbd_pkg::CNT_W) + 1;

    // Slot memory
    logic signed [rbd_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [rbd_pkg::DATA_W-1:0] r_rd_data;

    // Control state
    logic [rbd_pkg::CNT_W-1:0] r_ring_size;
    logic [SW-1:0]             r_head, n_head;
    logic [SW-1:0]             r_tail, n_tail;
    logic [rbd_pkg::CNT_W-1:0] r_count, n_count;
    logic                      r_valid;
    logic                      r_rd_sel, n_rd_sel;
    rbd_pkg::t_out             r_out, n_out;

    logic                      accept;
    logic [CW-1:0]             cap;
    logic [CW-1:0]             count_x;
    logic [SW-1:0]             head_next, head_prev, tail_next, tail_prev;
    logic                      wr_en;
    logic [SW-1:0]             wr_addr;
    logic [SW-1:0]             rd_addr;
    logic                      rd_en;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Capacity in use: ring size clamped to 1..DEPTH
    always_comb begin
        cap = CW'(r_ring_size);
        if (r_ring_size == '0) begin
            cap = CW'(1);
        end else if (CW'(r_ring_size) > CW'(DEPTH)) begin
            cap = CW'(DEPTH);
        end
    end

    assign count_x = CW'(r_count);

    // Ring neighbours of head and tail within the capacity in use
    assign head_next = (CW'(r_head) + CW'(1) >= cap) ? '0 : SW'(CW'(r_head) + CW'(1));
    assign tail_next = (CW'(r_tail) + CW'(1) >= cap) ? '0 : SW'(CW'(r_tail) + CW'(1));
    assign head_prev = (r_head == '0) ? SW'(cap - CW'(1)) : SW'(r_head - SW'(1));
    assign tail_prev = (r_tail == '0) ? SW'(cap - CW'(1)) : SW'(r_tail - SW'(1));

    // Request decode and pointer update
    always_comb begin
        logic at_front;
        logic [rbd_pkg::CNT_W-1:0] cnt_dec;
        at_front  = 1'b0;
        cnt_dec   = r_count - rbd_pkg::CNT_W'(1);
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_rd_sel  = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        rd_en     = 1'b0;
        rd_addr   = r_head;
        n_out     = '0;
        n_out.data_out = '0;
        n_out.status   = rbd_pkg::ST_OK;

        unique case (i_req.req_type) inside
            rbd_pkg::REQ_PUSH_FRONT, rbd_pkg::REQ_PUSH_BACK: begin
                if (count_x >= cap) begin
                    n_out.status = rbd_pkg::ST_FULL;
                end else begin
                    wr_en = 1'b1;
                    if (r_count == '0) begin
                        n_head  = '0;
                        n_tail  = '0;
                        wr_addr = '0;
                    end else if (i_req.req_type == rbd_pkg::REQ_PUSH_FRONT) begin
                        n_head  = head_prev;
                        wr_addr = head_prev;
                    end else begin
                        n_tail  = tail_next;
                        wr_addr = tail_next;
                    end
                    n_count = r_count + rbd_pkg::CNT_W'(1);
                end
            end
            rbd_pkg::REQ_POP_FRONT, rbd_pkg::REQ_POP_BACK,
            rbd_pkg::REQ_PEEK_FRONT, rbd_pkg::REQ_PEEK_BACK: begin
                at_front = (i_req.req_type == rbd_pkg::REQ_POP_FRONT) ||
                           (i_req.req_type == rbd_pkg::REQ_PEEK_FRONT);
                if (r_count == '0) begin
                    n_out.data_out = rbd_pkg::EMPTY_WORD;
                    n_out.status   = rbd_pkg::ST_EMPTY;
                end else begin
                    rd_en    = 1'b1;
                    n_rd_sel = 1'b1;
                    rd_addr  = at_front ? r_head : r_tail;
                    if ((i_req.req_type == rbd_pkg::REQ_POP_FRONT) ||
                        (i_req.req_type == rbd_pkg::REQ_POP_BACK)) begin
                        n_count = cnt_dec;
                        if (cnt_dec == '0) begin
                            n_head = '0;
                            n_tail = '0;
                        end else if (at_front) begin
                            n_head = head_next;
                        end else begin
                            n_tail = tail_prev;
                        end
                    end
                end
            end
            default: begin
                // unknown request: state untouched, zero word, status ok
            end
        endcase

        n_out.item_count = n_count;
        n_out.is_empty   = (n_count == '0);
        n_out.is_full    = (CW'(n_count) == cap);
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_mem[wr_addr] <= i_req.push_value;
        end
        if (accept && rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Pointers, count and ring size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= rbd_pkg::RING_SIZE_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
        end else if (i_cfg_we) begin
            r_ring_size <= i_cfg_data;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
        end else if (accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out    <= n_out;
            r_rd_sel <= n_rd_sel;
        end
    end

    // Read data replaces the word for pops and peeks that hit the memory
    always_comb begin
        o_result = r_out;
        if (r_rd_sel) begin
            o_result.data_out = r_rd_data;
        end
    end

    assign o_valid = r_valid;

`ifndef NO_ASSERTIONS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted request gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_valid)
        else $error("result without a request");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count_x <= cap)
        else $error("fill count above capacity");

    a_empty_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> ((r_head == '0) && (r_tail == '0)))
        else $error("empty deque with ends away from slot 0");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == rbd_pkg::ST_FULL)) |-> o_result.is_full)
        else $error("push rejected while not full");
`endif

endmodule

// File: tb/ring_buffer_deque_top_tb.sv
// ring_buffer_deque_top_tb: self-checking bench for the ring buffer deque.
// Drives directed and random requests and ring size writes, predicts each result.
// Depends on rbd_pkg and ring_buffer_deque_top.
`timescale 1ns / 1ps

module ring_buffer_deque_top_tb;

    // Codes with no meaning to the block: must leave the deque untouched
    localparam logic [rbd_pkg::REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [rbd_pkg::REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

    localparam int SETTLE_EDGES = 2;
    localparam int STALL_LIMIT  = 2000;

    // Planned stimulus: a request, a ring size write, or a wait for all results
    typedef enum logic [1:0] {STEP_REQ, STEP_SIZE, STEP_DRAIN} t_step_kind;

    typedef struct packed {
        t_step_kind                kind;
        rbd_pkg::t_in              rq;
        logic [rbd_pkg::CNT_W-1:0] size;
        logic [6:0]                gap_pct;
    } t_step;

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      start      = 1'b0;
    logic                      busy;
    rbd_pkg::t_in              i_req      = '0;
    logic                      o_valid;
    rbd_pkg::t_out             o_result;
    logic                      i_cfg_we   = 1'b0;
    logic [rbd_pkg::CNT_W-1:0] i_cfg_data = '0;

    t_step         step_plan [$];
    rbd_pkg::t_out due_results [$];

    // Own copy of the deque state
    logic signed [rbd_pkg::DATA_W-1:0] mdl_slots [rbd_pkg::DEPTH_DEFAULT];
    int unsigned                       mdl_head = 0;
    int unsigned                       mdl_tail = 0;
    int unsigned                       mdl_fill = 0;
    logic [rbd_pkg::CNT_W-1:0]         mdl_size = rbd_pkg::RING_SIZE_RESET;

    int unsigned gap_now    = 0;
    int unsigned quiet_cnt  = 0;
    int unsigned stall_cnt  = 0;
    int unsigned n_err      = 0;
    int unsigned n_sent     = 0;
    int unsigned n_checked  = 0;
    int unsigned n_refused  = 0;
    int unsigned n_on_empty = 0;
    int unsigned n_sizes    = 0;

    ring_buffer_deque_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Capacity in use: 0 behaves as 1, anything above the store depth as the depth
    function automatic int unsigned deque_cap();
        if (mdl_size == 0) return 1;
        if (mdl_size > rbd_pkg::DEPTH_DEFAULT) return rbd_pkg::DEPTH_DEFAULT;
        return 32'(mdl_size);
    endfunction

    // Apply one request to the local deque and work out its result
    function automatic rbd_pkg::t_out deque_step(rbd_pkg::t_in rq);
        rbd_pkg::t_out res;
        int unsigned   cap;
        logic          at_front;
        cap            = deque_cap();
        res.data_out   = '0;
        res.status     = rbd_pkg::ST_OK;
        case (rq.req_type) inside
            rbd_pkg::REQ_PUSH_FRONT, rbd_pkg::REQ_PUSH_BACK: begin
                if (mdl_fill >= cap) begin
                    res.status = rbd_pkg::ST_FULL;
                end else begin
                    if (mdl_fill == 0) begin
                        // empty deque restarts at slot 0 from either side
                        mdl_head     = 0;
                        mdl_tail     = 0;
                        mdl_slots[0] = rq.push_value;
                    end else if (rq.req_type == rbd_pkg::REQ_PUSH_FRONT) begin
                        mdl_head            = (mdl_head == 0) ? cap - 1 : mdl_head - 1;
                        mdl_slots[mdl_head] = rq.push_value;
                    end else begin
                        mdl_tail            = (mdl_tail + 1 >= cap) ? 0 : mdl_tail + 1;
                        mdl_slots[mdl_tail] = rq.push_value;
                    end
                    mdl_fill++;
                end
            end
            rbd_pkg::REQ_POP_FRONT, rbd_pkg::REQ_POP_BACK,
            rbd_pkg::REQ_PEEK_FRONT, rbd_pkg::REQ_PEEK_BACK: begin
                at_front = (rq.req_type == rbd_pkg::REQ_POP_FRONT) ||
                           (rq.req_type == rbd_pkg::REQ_PEEK_FRONT);
                if (mdl_fill == 0) begin
                    res.data_out = rbd_pkg::EMPTY_WORD;
                    res.status   = rbd_pkg::ST_EMPTY;
                end else begin
                    res.data_out = at_front ? mdl_slots[mdl_head] : mdl_slots[mdl_tail];
                    if (rq.req_type == rbd_pkg::REQ_POP_FRONT ||
                        rq.req_type == rbd_pkg::REQ_POP_BACK) begin
                        mdl_fill--;
                        if (mdl_fill == 0) begin
                            mdl_head = 0;
                            mdl_tail = 0;
                        end else if (at_front) begin
                            mdl_head = (mdl_head + 1 >= cap) ? 0 : mdl_head + 1;
                        end else begin
                            mdl_tail = (mdl_tail == 0) ? cap - 1 : mdl_tail - 1;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.item_count = rbd_pkg::CNT_W'(mdl_fill);
        res.is_empty   = (mdl_fill == 0);
        res.is_full    = (mdl_fill == cap);
        return res;
    endfunction

    task automatic plan_req(logic [rbd_pkg::REQ_W-1:0] code,
                            logic signed [rbd_pkg::DATA_W-1:0] word);
        t_step s;
        s.kind          = STEP_REQ;
        s.rq.req_type   = code;
        s.rq.push_value = word;
        s.size          = '0;
        s.gap_pct       = 7'(gap_now);
        step_plan       = {step_plan, s};
    endtask

    task automatic plan_size(logic [rbd_pkg::CNT_W-1:0] size);
        t_step s;
        s         = '0;
        s.kind    = STEP_SIZE;
        s.size    = size;
        step_plan = {step_plan, s};
    endtask

    task automatic plan_drain();
        t_step s;
        s         = '0;
        s.kind    = STEP_DRAIN;
        step_plan = {step_plan, s};
    endtask

    // Driver: predicts accepted transactions, then offers the next planned step
    always @(posedge i_clk) begin : drv
        t_step         nxt;
        rbd_pkg::t_out pred;
        logic          nx_start;
        logic          nx_we;
        if (!i_rst_n) begin
            start     <= 1'b0;
            i_cfg_we  <= 1'b0;
            quiet_cnt = 0;
        end else begin
            nx_start = 1'b0;
            nx_we    = 1'b0;
            // a ring size write empties the deque
            if (i_cfg_we) begin
                mdl_size = i_cfg_data;
                mdl_fill = 0;
                mdl_head = 0;
                mdl_tail = 0;
                n_sizes++;
            end
            if (start && !busy) begin
                pred        = deque_step(i_req);
                due_results = {due_results, pred};
                n_sent++;
                if (pred.status == rbd_pkg::ST_FULL) n_refused++;
                if (pred.status == rbd_pkg::ST_EMPTY) n_on_empty++;
            end
            if (!start && !o_valid && !i_cfg_we && due_results.size() == 0)
                quiet_cnt++;
            else
                quiet_cnt = 0;

            if (start && busy) begin
                nx_start = 1'b1;
            end else if (step_plan.size() > 0) begin
                case (step_plan[0].kind)
                    STEP_REQ: begin
                        if ($urandom_range(99, 0) >= step_plan[0].gap_pct) begin
                            nxt      = step_plan[0];
                            step_plan.delete(0);
                            i_req    <= nxt.rq;
                            nx_start = 1'b1;
                        end
                    end
                    STEP_SIZE: begin
                        if (quiet_cnt >= SETTLE_EDGES) begin
                            nxt        = step_plan[0];
                            step_plan.delete(0);
                            i_cfg_data <= nxt.size;
                            nx_we      = 1'b1;
                        end
                    end
                    default: begin
                        if (quiet_cnt >= SETTLE_EDGES) step_plan.delete(0);
                    end
                endcase
            end
            start    <= nx_start;
            i_cfg_we <= nx_we;
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction
    always @(posedge i_clk) begin : mon
        rbd_pkg::t_out want;
        logic          bad;
        if (i_rst_n && o_valid) begin
            if (due_results.size() == 0) begin
                if (n_err < 10)
                    $display("ERROR: result with nothing outstanding: %h", o_result);
                n_err++;
            end else begin
                want = due_results[0];
                due_results.delete(0);
                n_checked++;
                bad = 1'b0;
                if (o_result.data_out !== want.data_out) bad = 1'b1;
                if (o_result.status !== want.status) bad = 1'b1;
                if (o_result.item_count !== want.item_count) bad = 1'b1;
                if (o_result.is_empty !== want.is_empty) bad = 1'b1;
                if (o_result.is_full !== want.is_full) bad = 1'b1;
                if (bad) begin
                    if (n_err < 10) begin
                        $display("ERROR: result %0d: want data %0d st %0d cnt %0d e %b f %b",
                                 n_checked, want.data_out, want.status, want.item_count,
                                 want.is_empty, want.is_full);
                        $display("       got data %0d st %0d cnt %0d e %b f %b",
                                 o_result.data_out, o_result.status, o_result.item_count,
                                 o_result.is_empty, o_result.is_full);
                    end
                    n_err++;
                end
            end
        end
    end

    // Watchdog: cycles with no transaction of any kind
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("ring_buffer_deque_top_tb NOT OK");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin : stim
        int unsigned                       gap_by_phase [3];
        int unsigned                       r;
        int unsigned                       burst_left;
        logic                              filling;
        logic [rbd_pkg::CNT_W-1:0]         size;
        logic signed [rbd_pkg::DATA_W-1:0] word;
        logic [rbd_pkg::REQ_W-1:0]         code;

        for (int i = 0; i < rbd_pkg::DEPTH_DEFAULT; i++) mdl_slots[i] = '0;

        // Directed: empty answers, extreme words, every request, small rings
        gap_now = 0;
        plan_req(rbd_pkg::REQ_POP_FRONT, 32'sh7FFF_FFFF);
        plan_req(rbd_pkg::REQ_POP_BACK, 0);
        plan_req(rbd_pkg::REQ_PEEK_FRONT, 0);
        plan_req(rbd_pkg::REQ_PEEK_BACK, 0);
        plan_req(rbd_pkg::REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
        plan_req(rbd_pkg::REQ_PUSH_BACK, 32'sh8000_0000);
        plan_req(rbd_pkg::REQ_PUSH_FRONT, 0);
        plan_req(rbd_pkg::REQ_PUSH_BACK, -1);
        plan_req(rbd_pkg::REQ_PEEK_FRONT, 0);
        plan_req(rbd_pkg::REQ_PEEK_BACK, 0);
        plan_req(REQ_UNUSED_6, 32'sh1234_5678);
        plan_req(REQ_UNUSED_7, -1);
        plan_req(rbd_pkg::REQ_POP_FRONT, 0);
        plan_req(rbd_pkg::REQ_POP_BACK, 0);
        plan_req(rbd_pkg::REQ_POP_FRONT, 0);
        plan_req(rbd_pkg::REQ_POP_BACK, 0);
        // goes back into slot 0, then a size write throws it away
        plan_req(rbd_pkg::REQ_PUSH_BACK, 32'sh5555_5555);
        plan_size(5'd1);
        plan_req(rbd_pkg::REQ_PUSH_FRONT, 32'shAAAA_AAAA);
        plan_req(rbd_pkg::REQ_PUSH_BACK, 7);
        plan_req(rbd_pkg::REQ_PUSH_FRONT, 8);
        plan_req(rbd_pkg::REQ_PEEK_BACK, 0);
        plan_req(rbd_pkg::REQ_POP_FRONT, 0);
        plan_req(rbd_pkg::REQ_POP_BACK, 0);
        plan_size(5'd0);
        plan_req(rbd_pkg::REQ_PUSH_BACK, 9);
        plan_req(rbd_pkg::REQ_PUSH_FRONT, 10);
        plan_size(5'd31);

        // Random: fill and drain bursts over a spread of ring sizes
        gap_by_phase[0] = 21;
        gap_by_phase[1] = 85;
        gap_by_phase[2] = 0;
        for (int ph = 0; ph < 3; ph++) begin
            gap_now = gap_by_phase[ph];
            for (int blk = 0; blk < 10; blk++) begin
                case (blk)
                    0: size = 5'd1;
                    1: size = 5'd16;
                    2: size = 5'd0;
                    3: size = 5'($urandom_range(31, 17));
                    default: size = 5'($urandom_range(15, 2));
                endcase
                if (blk != 0 || ph != 0) plan_size(size);
                filling    = 1'b1;
                burst_left = $urandom_range(30, 8);
                for (int k = 0; k < 51; k++) begin
                    if (blk == 5 && k == 25) plan_drain();
                    if (burst_left == 0) begin
                        filling    = !filling;
                        burst_left = $urandom_range(30, 8);
                    end
                    burst_left--;
                    word = $urandom;
                    case ($urandom_range(9, 0))
                        0: word = 32'sh7FFF_FFFF;
                        1: word = 32'sh8000_0000;
                        2: word = 0;
                        3: word = -1;
                        default: ;
                    endcase
                    r = $urandom_range(99, 0);
                    if (r < 3)
                        code = $urandom_range(1, 0) ? REQ_UNUSED_6 : REQ_UNUSED_7;
                    else if (r < 13)
                        code = $urandom_range(1, 0) ? rbd_pkg::REQ_PEEK_FRONT
                                                    : rbd_pkg::REQ_PEEK_BACK;
                    else if ((r < 70) == filling)
                        code = $urandom_range(1, 0) ? rbd_pkg::REQ_PUSH_FRONT
                                                    : rbd_pkg::REQ_PUSH_BACK;
                    else
                        code = $urandom_range(1, 0) ? rbd_pkg::REQ_POP_FRONT
                                                    : rbd_pkg::REQ_POP_BACK;
                    plan_req(code, word);
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (step_plan.size() != 0 || due_results.size() != 0 || start)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $display("ERROR: %0d results never arrived", due_results.size());
            n_err++;
        end

        $display("Ran %0d requests over %0d ring size writes, %0d results checked.",
                 n_sent, n_sizes, n_checked);
        $display("Pushes refused as full: %0d, pops or peeks on empty: %0d, errors: %0d",
                 n_refused, n_on_empty, n_err);
        if (n_err == 0)
            $display("ring_buffer_deque_top_tb OK");
        else
            $display("ring_buffer_deque_top_tb NOT OK");
        $finish;
    end

endmodule

// File: files.f
src/rbd_pkg.sv
src/ring_buffer_deque_top.sv
tb/ring_buffer_deque_top_tb.sv
